[sv/rarmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_pkg
// Shared constants and control types for the range assign / range min unit.
// ----------------------------------------------------------------------------
package rarmt_pkg;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int SLOT_W         = 11;
	localparam int DATA_W         = 32;
	// wide enough to hold any legal LEAVES itself
	localparam int CNT_W          = 17;

	localparam logic FUNC_ASSIGN = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic clear;
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
		logic clr_last;
		logic is_query;
	} dp_status_t;

endpackage

[sv/rarmt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_req_if / rarmt_rsp_if
// Valid/ready channels for requests and minimum results.
// ----------------------------------------------------------------------------
interface rarmt_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [rarmt_pkg::SLOT_W-1:0] lo;
	logic [rarmt_pkg::SLOT_W-1:0] hi;
	logic [rarmt_pkg::DATA_W-1:0] value;
	modport source (output valid, func, lo, hi, value, input ready);
	modport sink (input valid, func, lo, hi, value, output ready);
endinterface

interface rarmt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rarmt_pkg::DATA_W-1:0] min_value;
	modport source (output valid, min_value, input ready);
	modport sink (input valid, min_value, output ready);
endinterface

[sv/rarmt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_dp
// Slot memory, range pointer and running minimum.
// ----------------------------------------------------------------------------
module rarmt_dp #(
	parameter int LEAVES     = rarmt_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = rarmt_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rarmt_pkg::ctrl_cmd_t         cmd,
	output rarmt_pkg::dp_status_t        status,
	input  logic                         func,
	input  logic [rarmt_pkg::SLOT_W-1:0] lo,
	input  logic [rarmt_pkg::SLOT_W-1:0] hi,
	input  logic [rarmt_pkg::DATA_W-1:0] value,
	output logic [rarmt_pkg::DATA_W-1:0] min_value
);
	localparam int AW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam logic [rarmt_pkg::CNT_W-1:0] LIM  = rarmt_pkg::CNT_W'(LEAVES);
	localparam logic [rarmt_pkg::CNT_W-1:0] LAST = rarmt_pkg::CNT_W'(LEAVES - 1);
	localparam logic [VALUE_BITS-1:0] SENT = '1;

	logic [VALUE_BITS-1:0] mem [LEAVES];
	logic [VALUE_BITS-1:0] rdata_s1;
	logic                  rd_s1;
	logic [VALUE_BITS-1:0] acc_q, val_q;
	logic [rarmt_pkg::CNT_W-1:0] ptr_q, end_q, lo_e, hi_e, lo_c, hi_c;
	logic func_q, we;

	// clip range to the slot count
	always_comb begin
		lo_e = rarmt_pkg::CNT_W'(lo);
		hi_e = rarmt_pkg::CNT_W'(hi);
		lo_c = (lo_e > LIM) ? LIM : lo_e;
		hi_c = (hi_e > LIM) ? LIM : hi_e;
	end

	assign we = cmd.clear | (cmd.step & (func_q == rarmt_pkg::FUNC_ASSIGN));

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[ptr_q[AW-1:0]] <= cmd.clear ? SENT : val_q;
		end
		rdata_s1 <= mem[ptr_q[AW-1:0]];
	end

	// range pointer and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			end_q  <= '0;
			func_q <= rarmt_pkg::FUNC_ASSIGN;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= cmd.step & (func_q == rarmt_pkg::FUNC_QUERY);
			if (cmd.load) begin
				ptr_q  <= lo_c;
				end_q  <= (lo_c < hi_c) ? hi_c : lo_c;
				func_q <= func;
			end else if (cmd.clear || cmd.step) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// hold the request value and fold read data into the minimum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= VALUE_BITS'(value);
			acc_q <= SENT;
		end else if (rd_s1 && rdata_s1 < acc_q) begin
			acc_q <= rdata_s1;
		end
	end

	assign status.done     = (ptr_q == end_q);
	assign status.clr_last = (ptr_q == LAST);
	assign status.is_query = (func_q == rarmt_pkg::FUNC_QUERY);
	assign min_value       = rarmt_pkg::DATA_W'(acc_q);

endmodule

[sv/rarmt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_ctrl
// Sequencer: clearing pass, request intake, slot sweep and result handoff.
// ----------------------------------------------------------------------------
module rarmt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rarmt_pkg::ctrl_cmd_t  cmd,
	input  rarmt_pkg::dp_status_t status
);
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!status.done) begin
					cmd.step = 1'b1;
				end else begin
					state_d = status.is_query ? ST_DRAIN : ST_IDLE;
				end
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

endmodule

[sv/range_assign_range_min_tree_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_assign_range_min_tree_unit
// Range assign and range minimum over LEAVES slots.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | func, lo, hi, value
//  rsp     | out | min_value (queries only)
//
// The sweep does one slot memory access per cycle over the range after clipping
// to LEAVES (no slots when the range is empty); a query also waits for rsp.ready.
// After reset a clearing pass writes the sentinel to every slot; req.ready
// stays low until it ends.
// One request is in work at a time; req.ready is low while a result waits.
module range_assign_range_min_tree_unit #(
	parameter int LEAVES     = rarmt_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = rarmt_pkg::VALUE_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	rarmt_req_if.sink    req,
	rarmt_rsp_if.source  rsp
);
	rarmt_pkg::ctrl_cmd_t  cmd;
	rarmt_pkg::dp_status_t status;

	rarmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	rarmt_dp #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.func      (req.func),
		.lo        (req.lo),
		.hi        (req.hi),
		.value     (req.value),
		.min_value (rsp.min_value)
	);

endmodule

[dv/range_min_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the range assign / range minimum unit against a flat slot array.
// Directed edge cases first, then random assigns and queries, with random
// idling on the request and result channels, and none in the last part.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LEAVES = rarmt_pkg::LEAVES_DEF;
	localparam int N_RAND = 1400;
	localparam int LIMIT  = 10000000;

	// track expected minimums in arrival order
	class min_scoreboard;
		logic [rarmt_pkg::DATA_W-1:0] slots [LEAVES];
		logic [rarmt_pkg::DATA_W-1:0] pending [$];
		int errors;

		function new();
			foreach (slots[i]) slots[i] = '1;
			errors = 0;
		endfunction

		// apply one accepted request to the slot image
		function void note_request(logic f, logic [rarmt_pkg::SLOT_W-1:0] lo_in,
				logic [rarmt_pkg::SLOT_W-1:0] hi_in, logic [rarmt_pkg::DATA_W-1:0] v);
			int l, h;
			logic [rarmt_pkg::DATA_W-1:0] m;
			l = (int'(lo_in) > LEAVES) ? LEAVES : int'(lo_in);
			h = (int'(hi_in) > LEAVES) ? LEAVES : int'(hi_in);
			m = '1;
			if (f == rarmt_pkg::FUNC_ASSIGN) begin
				for (int i = l; i < h; i++) slots[i] = v;
			end else begin
				for (int i = l; i < h; i++) if (slots[i] < m) m = slots[i];
				pending.insert(pending.size(), m);
			end
		endfunction

		function void check_result(logic [rarmt_pkg::DATA_W-1:0] got);
			logic [rarmt_pkg::DATA_W-1:0] exp_v;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_v = pending[0];
			pending.delete(0);
			if (got !== exp_v) begin
				errors++;
				if (errors <= 10) $display("min_value mismatch: exp %h got %h", exp_v, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit quiet = 0;
	int cycles = 0;
	min_scoreboard sb = new();

	rarmt_req_if req ();
	rarmt_rsp_if rsp ();

	range_assign_range_min_tree_unit i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #2 clk = ~clk;

	initial begin
		req.valid = 0;
		req.func = 0;
		req.lo = 0;
		req.hi = 0;
		req.value = 0;
		rsp.ready = 0;
	end

	// note accepted requests and check results
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (req.valid && req.ready) sb.note_request(req.func, req.lo, req.hi, req.value);
		if (rsp.valid && rsp.ready) sb.check_result(rsp.min_value);
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// stall the result side in random bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				rsp.ready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				rsp.ready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic send_request(logic f, int l, int h, logic [rarmt_pkg::DATA_W-1:0] v);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			req.valid <= 0;
			repeat (n) @(posedge clk);
		end
		req.valid <= 1;
		req.func <= f;
		req.lo <= l[rarmt_pkg::SLOT_W-1:0];
		req.hi <= h[rarmt_pkg::SLOT_W-1:0];
		req.value <= v;
		do @(posedge clk); while (!req.ready);
	endtask

	// mostly short ranges so the sweep stays quick
	task automatic send_random();
		int l, h, w;
		logic [rarmt_pkg::DATA_W-1:0] v;
		l = $urandom_range(0, LEAVES - 1);
		w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, LEAVES) : $urandom_range(0, 16);
		h = l + w;
		if ($urandom_range(0, 15) == 0) h = $urandom_range(0, 2047);
		if ($urandom_range(0, 31) == 0) l = $urandom_range(0, 2047);
		case ($urandom_range(0, 7))
			0: v = '1;
			1: v = 0;
			default: v = $urandom();
		endcase
		send_request(1'($urandom_range(0, 1)), l, h, v);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		// directed: empty tree, full ranges, clipping, empty and sentinel cases
		send_request(rarmt_pkg::FUNC_QUERY, 0, LEAVES, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 5, 5, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 0, LEAVES, 32'h8000_0000);
		send_request(rarmt_pkg::FUNC_QUERY, 0, 1, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 3, 4, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 0, LEAVES, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 10, 2, 7);
		send_request(rarmt_pkg::FUNC_QUERY, 2, 10, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 9, 3, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 1000, 2047, 32'h1234_5678);
		send_request(rarmt_pkg::FUNC_QUERY, 1020, 2047, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 2047, 2047, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 1024, 2047, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 2047, 1024, 5);
		send_request(rarmt_pkg::FUNC_ASSIGN, 0, 8, '1);
		send_request(rarmt_pkg::FUNC_QUERY, 0, 8, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 0, 3, 32'hffff_ffff);
		send_request(rarmt_pkg::FUNC_ASSIGN, 1023, 1024, 32'h7fff_ffff);
		send_request(rarmt_pkg::FUNC_QUERY, 1023, 1024, 0);
		send_request(rarmt_pkg::FUNC_QUERY, 512, 1024, 0);
		send_request(rarmt_pkg::FUNC_ASSIGN, 512, 513, 1);
		send_request(rarmt_pkg::FUNC_QUERY, 0, LEAVES, 0);
		for (int i = 0; i < N_RAND; i++) begin
			if (i == N_RAND - 150) quiet = 1;
			send_random();
		end
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
